// ===== rtl/core/swmq_pkg.sv =====
// ----------------------------------------------------------------------------
// swmq_pkg
// Shared codes and controller/datapath interface types for the stack with
// median query block.
// ----------------------------------------------------------------------------
`default_nettype none

package swmq_pkg;

  localparam int VALUE_W  = 16;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  typedef logic [ACTION_W-1:0] swmq_action_t;
  typedef logic [STATUS_W-1:0] swmq_status_t;
  typedef logic [1:0]          swmq_sel_t;

  // request codes
  localparam swmq_action_t ACT_PUSH   = 2'd0;
  localparam swmq_action_t ACT_POP    = 2'd1;
  localparam swmq_action_t ACT_MEDIAN = 2'd2;

  // result status codes
  localparam swmq_status_t ST_OK    = 2'd0;
  localparam swmq_status_t ST_EMPTY = 2'd1;
  localparam swmq_status_t ST_FULL  = 2'd2;

  // result value source
  localparam swmq_sel_t RES_ZERO   = 2'd0;
  localparam swmq_sel_t RES_ITEM   = 2'd1;
  localparam swmq_sel_t RES_MEDIAN = 2'd2;

  typedef struct packed {
    logic         clr_step;
    logic         load_in;
    logic         div_start;
    logic         stk_rd;
    logic         pop_load;
    logic         push_wr;
    logic         pop_wr;
    logic         med_init;
    logic         med_bstep;
    logic         med_vinit;
    logic         med_vstep;
    logic         res_load;
    swmq_status_t res_status;
    swmq_sel_t    res_sel;
  } swmq_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic full;
    logic empty;
    logic b_stop;
    logic v_stop;
  } swmq_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/swmq_dpath.sv =====
// ----------------------------------------------------------------------------
// swmq_dpath
// Datapath: stack memory, value and bucket count memories, bucket index
// multiplier, median walk registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swmq_dpath #(
  parameter int VALUE_COUNT = 65536,
  parameter int BUCKET_SIZE = 256,
  parameter int STACK_DEPTH = 1024
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  [swmq_pkg::VALUE_W-1:0] in_value,
  input  swmq_pkg::swmq_cmd_t         cmd,
  output swmq_pkg::swmq_sts_t         sts,
  output logic [swmq_pkg::STATUS_W-1:0] out_status,
  output logic [swmq_pkg::VALUE_W-1:0]  out_result_value
);

  localparam int VW  = swmq_pkg::VALUE_W;
  localparam int BT  = (VALUE_COUNT + BUCKET_SIZE - 1) / BUCKET_SIZE;
  localparam int VIW = $clog2(VALUE_COUNT);
  localparam int BIW = (BT > 1) ? $clog2(BT) : 1;
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int KW  = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
  localparam int BSL = $clog2(BUCKET_SIZE);
  localparam int SHW = VW + BSL;
  localparam int PW  = 2 * VW + 1;
  localparam int VMAX = (VALUE_COUNT > (1 << VW)) ? ((1 << VW) - 1) : (VALUE_COUNT - 1);

  localparam logic [VW-1:0]  VMAX_V = VW'(VMAX);
  localparam logic [BIW-1:0] B_LAST = BIW'(BT - 1);
  localparam logic [VIW-1:0] V_LAST = VIW'(VALUE_COUNT - 1);
  localparam logic [KW-1:0]  K_LAST = KW'(BUCKET_SIZE - 1);
  localparam logic [VIW-1:0] BS_V   = VIW'(BUCKET_SIZE);
  localparam logic [VIW:0]   BT_L   = (VIW + 1)'(BT);
  localparam logic [CW-1:0]  FULL_C = CW'(STACK_DEPTH);
  // rounded-up reciprocal of the bucket size, exact for every 16-bit value
  localparam logic [VW:0]    RECIP  =
      (VW + 1)'(((1 << SHW) + BUCKET_SIZE - 1) / BUCKET_SIZE);

  // memories
  logic [VW-1:0] stk_mem [STACK_DEPTH];
  logic [CW-1:0] vc_mem  [VALUE_COUNT];
  logic [CW-1:0] bc_mem  [BT];

  logic [VW-1:0]  stk_rd_r;
  logic [CW-1:0]  vc_rd_r;
  logic [CW-1:0]  bc_rd_r;

  logic [VIW-1:0] clr_r;
  logic [CW-1:0]  count_r;
  logic [VW-1:0]  item_val_r;

  logic [BIW-1:0] quo_r;

  logic [CW-1:0]  rank_r;
  logic [CW-1:0]  sum_r;
  logic [BIW-1:0] b_r;
  logic [VIW-1:0] vbase_r;
  logic [VIW-1:0] v_r;
  logic [KW-1:0]  k_r;

  logic [VIW-1:0] item_idx;
  logic [BIW-1:0] item_bkt;
  logic [PW-1:0]  prod;
  logic [CW:0]    sum_b;
  logic [CW:0]    sum_v;
  logic           b_cont;
  logic           v_cont;
  logic           bc_clr_en;

  logic           vc_we;
  logic [VIW-1:0] vc_wa;
  logic [CW-1:0]  vc_wd;
  logic [VIW-1:0] vc_ra;
  logic           bc_we;
  logic [BIW-1:0] bc_wa;
  logic [CW-1:0]  bc_wd;
  logic [BIW-1:0] bc_ra;
  logic [SAW-1:0] stk_wa;
  logic [SAW-1:0] stk_ra;

  assign item_idx  = VIW'(item_val_r);
  assign item_bkt  = quo_r;
  assign bc_clr_en = ({1'b0, clr_r} < BT_L);

  // bucket index by reciprocal multiplication
  assign prod = PW'(item_val_r) * PW'(RECIP);

  assign sum_b  = (CW + 1)'(sum_r) + (CW + 1)'(bc_rd_r);
  assign sum_v  = (CW + 1)'(sum_r) + (CW + 1)'(vc_rd_r);
  assign b_cont = (b_r != B_LAST) && (sum_b < {1'b0, rank_r});
  assign v_cont = (k_r != K_LAST) && (v_r != V_LAST) && (sum_v < {1'b0, rank_r});

  assign sts.clr_done = (clr_r == V_LAST);
  assign sts.full     = (count_r == FULL_C);
  assign sts.empty    = (count_r == '0);
  assign sts.b_stop   = !b_cont;
  assign sts.v_stop   = !v_cont;

  // read addresses: walk reads one entry ahead of the compare
  always_comb begin
    if (cmd.med_vinit) begin
      vc_ra = vbase_r;
    end else if (cmd.med_vstep && v_cont) begin
      vc_ra = VIW'(v_r + 1'b1);
    end else if (cmd.med_vstep) begin
      vc_ra = v_r;
    end else begin
      vc_ra = item_idx;
    end
    if (cmd.med_init) begin
      bc_ra = '0;
    end else if (cmd.med_bstep && b_cont) begin
      bc_ra = BIW'(b_r + 1'b1);
    end else if (cmd.med_bstep) begin
      bc_ra = b_r;
    end else begin
      bc_ra = item_bkt;
    end
  end

  always_comb begin
    vc_we = cmd.clr_step || cmd.push_wr || cmd.pop_wr;
    bc_we = (cmd.clr_step && bc_clr_en) || cmd.push_wr || cmd.pop_wr;
    vc_wa = cmd.clr_step ? clr_r : item_idx;
    bc_wa = cmd.clr_step ? BIW'(clr_r) : item_bkt;
    if (cmd.clr_step) begin
      vc_wd = '0;
      bc_wd = '0;
    end else if (cmd.push_wr) begin
      vc_wd = CW'(vc_rd_r + 1'b1);
      bc_wd = CW'(bc_rd_r + 1'b1);
    end else begin
      vc_wd = (vc_rd_r != '0) ? CW'(vc_rd_r - 1'b1) : vc_rd_r;
      bc_wd = (bc_rd_r != '0) ? CW'(bc_rd_r - 1'b1) : bc_rd_r;
    end
    stk_wa = SAW'(count_r);
    stk_ra = SAW'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (vc_we) begin
      vc_mem[vc_wa] <= vc_wd;
    end
    vc_rd_r <= vc_mem[vc_ra];
  end

  always_ff @(posedge clk) begin
    if (bc_we) begin
      bc_mem[bc_wa] <= bc_wd;
    end
    bc_rd_r <= bc_mem[bc_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      stk_mem[stk_wa] <= item_val_r;
    end
    if (cmd.stk_rd) begin
      stk_rd_r <= stk_mem[stk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      count_r <= '0;
    end else begin
      if (cmd.clr_step && !sts.clr_done) begin
        clr_r <= VIW'(clr_r + 1'b1);
      end
      if (cmd.push_wr) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (cmd.pop_wr) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_val_r <= (in_value > VMAX_V) ? VMAX_V : in_value;
    end else if (cmd.pop_load) begin
      item_val_r <= stk_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r <= BIW'(prod >> SHW);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.med_init) begin
      rank_r  <= CW'(((CW + 1)'(count_r) + 1'b1) >> 1);
      sum_r   <= '0;
      b_r     <= '0;
      vbase_r <= '0;
    end else if (cmd.med_bstep && b_cont) begin
      sum_r   <= CW'(sum_b);
      b_r     <= BIW'(b_r + 1'b1);
      vbase_r <= VIW'(vbase_r + BS_V);
    end else if (cmd.med_vstep && v_cont) begin
      sum_r <= CW'(sum_v);
    end
    if (cmd.med_vinit) begin
      v_r <= vbase_r;
      k_r <= '0;
    end else if (cmd.med_vstep && v_cont) begin
      v_r <= VIW'(v_r + 1'b1);
      k_r <= KW'(k_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status <= cmd.res_status;
      case (cmd.res_sel)
        swmq_pkg::RES_ITEM:   out_result_value <= item_val_r;
        swmq_pkg::RES_MEDIAN: out_result_value <= VW'(v_r);
        default:              out_result_value <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/swmq_ctrl.sv =====
// ----------------------------------------------------------------------------
// swmq_ctrl
// Controller: sequences the clearing pass, push, pop and median walk, and
// owns the input ready and output valid handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module swmq_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire  [swmq_pkg::ACTION_W-1:0] in_action,
  output logic                      out_valid,
  input  wire                       out_ready,
  input  swmq_pkg::swmq_sts_t       sts,
  output swmq_pkg::swmq_cmd_t       cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SLD   = 4'd3;
  localparam logic [3:0] S_DIV0  = 4'd4;
  localparam logic [3:0] S_CRD   = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_MINIT = 4'd8;
  localparam logic [3:0] S_MB    = 4'd9;
  localparam logic [3:0] S_MVI   = 4'd10;
  localparam logic [3:0] S_MV    = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0]             state_r, state_nxt;
  logic                   is_pop_r, is_pop_nxt;
  swmq_pkg::swmq_status_t fin_status_r, fin_status_nxt;
  swmq_pkg::swmq_sel_t    fin_sel_r, fin_sel_nxt;
  logic                   out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    state_nxt      = state_r;
    is_pop_nxt     = is_pop_r;
    fin_status_nxt = fin_status_r;
    fin_sel_nxt    = fin_sel_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt      = S_FIN;
          fin_status_nxt = swmq_pkg::ST_EMPTY;
          fin_sel_nxt    = swmq_pkg::RES_ZERO;
          case (in_action)
            swmq_pkg::ACT_PUSH: begin
              if (sts.full) begin
                fin_status_nxt = swmq_pkg::ST_FULL;
              end else begin
                cmd.load_in = 1'b1;
                is_pop_nxt  = 1'b0;
                state_nxt   = S_DIV0;
              end
            end
            swmq_pkg::ACT_POP: begin
              if (!sts.empty) begin
                is_pop_nxt = 1'b1;
                state_nxt  = S_SRD;
              end
            end
            swmq_pkg::ACT_MEDIAN: begin
              if (!sts.empty) begin
                state_nxt = S_MINIT;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SRD: begin
        cmd.stk_rd = 1'b1;
        state_nxt  = S_SLD;
      end
      S_SLD: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_DIV0;
      end
      S_DIV0: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_CRD;
      end
      S_CRD: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt      = S_FIN;
        fin_status_nxt = swmq_pkg::ST_OK;
        if (is_pop_r) begin
          cmd.pop_wr  = 1'b1;
          fin_sel_nxt = swmq_pkg::RES_ITEM;
        end else begin
          cmd.push_wr = 1'b1;
          fin_sel_nxt = swmq_pkg::RES_ZERO;
        end
      end
      S_MINIT: begin
        cmd.med_init = 1'b1;
        state_nxt    = S_MB;
      end
      S_MB: begin
        cmd.med_bstep = 1'b1;
        if (sts.b_stop) begin
          state_nxt = S_MVI;
        end
      end
      S_MVI: begin
        cmd.med_vinit = 1'b1;
        state_nxt     = S_MV;
      end
      S_MV: begin
        cmd.med_vstep = 1'b1;
        if (sts.v_stop) begin
          state_nxt      = S_FIN;
          fin_status_nxt = swmq_pkg::ST_OK;
          fin_sel_nxt    = swmq_pkg::RES_MEDIAN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = fin_status_r;
          cmd.res_sel    = fin_sel_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_pop_r     <= is_pop_nxt;
    fin_status_r <= fin_status_nxt;
    fin_sel_r    <= fin_sel_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/stack_with_median_query.sv =====
// ----------------------------------------------------------------------------
// stack_with_median_query
// Value stack with push, pop and median query, backed by per-value and
// per-bucket count memories.
//
//   Channel  Direction  Handshake            Word
//   in_      input      in_valid/in_ready    in_action, in_value
//   out_     output     out_valid/out_ready  out_status, out_result_value
//
// One request at a time, one result word per request.
// Push and pop compute the bucket index by multiply, then read the count
// memories and write them back; a pop first reads the stack.
// A median query walks the bucket counts and then the value counts in the
// chosen bucket, one count memory read per cycle in the bucket walk and then
// in the value walk. Errors go straight to the result.
// After reset a clearing pass zeroes the count memories; in_ready stays low
// meanwhile.
// Results sit in an output register; a new request is taken while one waits,
// and its result holds until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_median_query #(
  parameter int VALUE_COUNT = 65536,
  parameter int BUCKET_SIZE = 256,
  parameter int STACK_DEPTH = 1024
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [swmq_pkg::ACTION_W-1:0] in_action,
  input  wire  [swmq_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [swmq_pkg::STATUS_W-1:0] out_status,
  output logic [swmq_pkg::VALUE_W-1:0]  out_result_value
);

  swmq_pkg::swmq_cmd_t cmd;
  swmq_pkg::swmq_sts_t sts;

  swmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swmq_dpath #(
    .VALUE_COUNT (VALUE_COUNT),
    .BUCKET_SIZE (BUCKET_SIZE),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (out_status),
    .out_result_value (out_result_value)
  );

endmodule

`default_nettype wire

// ===== rtl/core/swmq_chk.sv =====
// ----------------------------------------------------------------------------
// swmq_chk
// Port-level checks for the stack with median query block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module swmq_chk (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           in_valid,
  input wire                           in_ready,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire [swmq_pkg::STATUS_W-1:0]  out_status,
  input wire [swmq_pkg::VALUE_W-1:0]   out_result_value
);

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
                                && $stable(out_result_value))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request taken while previous one in progress");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result word without a pending request");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != swmq_pkg::ST_OK |-> out_result_value == '0)
    else $error("error result carries a non-zero value");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == swmq_pkg::ST_OK || out_status == swmq_pkg::ST_EMPTY
                  || out_status == swmq_pkg::ST_FULL)
    else $error("unknown status code");

endmodule

bind stack_with_median_query swmq_chk u_swmq_chk (.*);

`default_nettype wire
